>>> design/xs64_pkg.sv
// ----------------------------------------------------------------------------
// xs64_pkg
// Shared constants and types of the xorshift64* whitener: operation codes,
// generator constants and the request/response bundles of the multiply unit.
// ----------------------------------------------------------------------------
package xs64_pkg;

   localparam int OP_W    = 2;
   localparam int SEED_W  = 64;
   localparam int WORD_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int PHASE_W = 2;

   localparam logic [OP_W-1:0] OP_RESEED = 2'd0;
   localparam logic [OP_W-1:0] OP_BYTE   = 2'd1;
   localparam logic [OP_W-1:0] OP_WORD   = 2'd2;

   localparam logic [SEED_W-1:0] SEED_INIT = 64'hFFFF_FFFF_FFFF_FFC5;
   localparam logic [SEED_W-1:0] MMIX_MUL  = 64'h5851_F42D_4C95_7F2D;
   localparam logic [SEED_W-1:0] MMIX_ADD  = 64'h1405_7B7E_F767_814F;
   localparam logic [SEED_W-1:0] STAR_MUL  = 64'h2545_F491_4F6C_DD1D;

   typedef struct packed {
      logic              start;
      logic [SEED_W-1:0] multiplicand;
      logic [SEED_W-1:0] multiplier;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic [SEED_W-1:0] product;
   } mul_rsp_type;

endpackage

>>> design/xs64_req_if.sv
// ----------------------------------------------------------------------------
// xs64_req_if
// Request channel: operation, seed value and buffer start with valid/ready.
// ----------------------------------------------------------------------------
interface xs64_req_if;

   logic                              valid;
   logic                              ready;
   logic [xs64_pkg::OP_W-1:0]         operation;
   logic signed [xs64_pkg::WORD_W-1:0] seed_value;
   logic                              buffer_start;

   modport source (output valid, output operation, output seed_value,
                   output buffer_start, input ready);
   modport sink   (input valid, input operation, input seed_value,
                   input buffer_start, output ready);

endinterface

>>> design/xs64_rsp_if.sv
// ----------------------------------------------------------------------------
// xs64_rsp_if
// Response channel: one random word or whitening byte per beat.
// ----------------------------------------------------------------------------
interface xs64_rsp_if;

   logic                        valid;
   logic                        ready;
   logic [xs64_pkg::WORD_W-1:0] random_value;

   modport source (output valid, output random_value, input ready);
   modport sink   (input valid, input random_value, output ready);

endinterface

>>> design/xorshift64star_byte_whitener.sv
// Sequence: a word item, or a byte item that draws a new word, runs the xorshift step,
// the star multiply and the response beat; a byte from the held word goes straight to
// the response beat; a reseed runs 4 MMIX-mixed products and gives no response.
// Items are taken one at a time, and every product runs on the shared 32x32
// multiplier.
// Reset: synchronous; seeds, held word and byte phase return to their initial values.
// ----------------------------------------------------------------------------
// xorshift64star_byte_whitener
// xorshift64* word source with whitening-byte output and MMIX-mixed reseed,
// sequenced around one iterative multiply unit.
// ----------------------------------------------------------------------------
module xorshift64star_byte_whitener (
   input  logic       clock,
   input  logic       reset,
   xs64_req_if.sink   req_bus,
   xs64_rsp_if.source rsp_bus
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_XSH   = 3'd1;
   localparam logic [2:0] S_ISSUE = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   localparam logic [1:0] ROUND_LAST = 2'd3;

   logic [2:0]                   state_ff, state_in;
   logic [xs64_pkg::OP_W-1:0]    op_ff, op_in;
   logic [1:0]                   round_ff, round_in;
   logic [xs64_pkg::SEED_W-1:0]  seed_main_ff, seed_main_in;
   logic [xs64_pkg::SEED_W-1:0]  seed_aux_ff, seed_aux_in;
   logic [xs64_pkg::WORD_W-1:0]  held_ff, held_in;
   logic [xs64_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [xs64_pkg::WORD_W-1:0]  result_ff, result_in;

   logic                         req_fire;
   logic [xs64_pkg::SEED_W-1:0]  ext;
   logic [xs64_pkg::SEED_W-1:0]  xs;
   logic [xs64_pkg::SEED_W-1:0]  mixed;
   logic [xs64_pkg::WORD_W-1:0]  drawn;
   xs64_pkg::mul_req_type        mul_req;
   xs64_pkg::mul_rsp_type        mul_rsp;

   xs64_mul_lo u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_bus.ready        = (state_ff == S_IDLE);
   assign req_fire             = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid        = (state_ff == S_RESP);
   assign rsp_bus.random_value = result_ff;

   always_comb begin
      ext   = {{(xs64_pkg::SEED_W - xs64_pkg::WORD_W){req_bus.seed_value[xs64_pkg::WORD_W-1]}},
               req_bus.seed_value};
      xs    = seed_main_ff ^ (seed_main_ff >> 12);
      xs    = xs ^ (xs << 25);
      xs    = xs ^ (xs >> 27);
      mixed = mul_rsp.product + xs64_pkg::MMIX_ADD;
      drawn = mul_rsp.product[xs64_pkg::SEED_W-1:xs64_pkg::WORD_W];
   end

   always_comb begin
      mul_req.start        = (state_ff == S_XSH) || (state_ff == S_ISSUE);
      mul_req.multiplicand = (state_ff == S_XSH) ? xs :
                             (round_ff[0] ? seed_main_ff : seed_aux_ff);
      mul_req.multiplier   = (state_ff == S_XSH) ? xs64_pkg::STAR_MUL : xs64_pkg::MMIX_MUL;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      round_in     = round_ff;
      seed_main_in = seed_main_ff;
      seed_aux_in  = seed_aux_ff;
      held_in      = held_ff;
      phase_in     = phase_ff;
      result_in    = result_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_bus.operation;
               round_in = 2'd0;
               case (req_bus.operation)
                  xs64_pkg::OP_RESEED: begin
                     seed_main_in = seed_main_ff ^ ext;
                     seed_aux_in  = seed_aux_ff ^ ext;
                     state_in     = S_ISSUE;
                  end
                  xs64_pkg::OP_WORD: begin
                     state_in = S_XSH;
                  end
                  xs64_pkg::OP_BYTE: begin
                     if (req_bus.buffer_start || (phase_ff == '0)) begin
                        state_in = S_XSH;
                     end else begin
                        result_in = {{(xs64_pkg::WORD_W - xs64_pkg::BYTE_W){1'b0}},
                                     held_ff[xs64_pkg::BYTE_W-1:0]};
                        held_in   = held_ff >> xs64_pkg::BYTE_W;
                        phase_in  = phase_ff + 1'b1;
                        state_in  = S_RESP;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_XSH: begin
            seed_main_in = xs;
            state_in     = S_MUL;
         end
         S_ISSUE: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            if (mul_rsp.done) begin
               if (op_ff == xs64_pkg::OP_RESEED) begin
                  case (round_ff)
                     2'd0, 2'd2: seed_aux_in = mixed;
                     2'd1:       seed_main_in = mixed;
                     default: begin
                        seed_main_in = seed_aux_ff;
                        seed_aux_in  = mixed;
                     end
                  endcase
                  if (round_ff == ROUND_LAST) begin
                     round_in = 2'd0;
                     state_in = S_IDLE;
                  end else begin
                     round_in = round_ff + 1'b1;
                     state_in = S_ISSUE;
                  end
               end else if (op_ff == xs64_pkg::OP_BYTE) begin
                  result_in = {{(xs64_pkg::WORD_W - xs64_pkg::BYTE_W){1'b0}},
                               drawn[xs64_pkg::BYTE_W-1:0]};
                  held_in   = drawn >> xs64_pkg::BYTE_W;
                  phase_in  = {{(xs64_pkg::PHASE_W-1){1'b0}}, 1'b1};
                  state_in  = S_RESP;
               end else begin
                  result_in = drawn;
                  state_in  = S_RESP;
               end
            end
         end
         S_RESP: begin
            if (rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= xs64_pkg::OP_RESEED;
         round_ff     <= 2'd0;
         seed_main_ff <= xs64_pkg::SEED_INIT;
         seed_aux_ff  <= '0;
         held_ff      <= '0;
         phase_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         round_ff     <= round_in;
         seed_main_ff <= seed_main_in;
         seed_aux_ff  <= seed_aux_in;
         held_ff      <= held_in;
         phase_ff     <= phase_in;
      end
      result_ff <= result_in;
   end

`ifndef SYNTHESIS
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !req_bus.ready)
      else $error("request accepted while a response beat is pending");

   a_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == S_MUL))
      else $error("multiply done outside the wait state");

   a_seeds_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && !mul_rsp.done) |=>
         ($stable(seed_main_ff) && $stable(seed_aux_ff)))
      else $error("seeds changed while the multiply is running");

   a_round_reseed: assert property (@(posedge clock) disable iff (reset)
      (round_ff != 2'd0) |-> (op_ff == xs64_pkg::OP_RESEED))
      else $error("mixing round advanced outside a reseed");
`endif

endmodule

>>> design/xs64_mul_lo.sv
// ----------------------------------------------------------------------------
// xs64_mul_lo
// Low 64 bits of a 64x64 product, built from the low-low, low-high and high-low
// partial products of one shared 32x32 multiplier and a 64-bit accumulator. Done
// pulses when the last partial product has been added to the accumulator.
// ----------------------------------------------------------------------------
module xs64_mul_lo (
   input  logic                  clock,
   input  logic                  reset,
   input  xs64_pkg::mul_req_type mul_req,
   output xs64_pkg::mul_rsp_type mul_rsp
);

   localparam int HALF_W = xs64_pkg::SEED_W / 2;

   localparam logic [1:0] STEP_LL = 2'd0;
   localparam logic [1:0] STEP_LH = 2'd1;
   localparam logic [1:0] STEP_HL = 2'd2;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [1:0]                  step_ff, step_in;
   logic [xs64_pkg::SEED_W-1:0] a_ff, a_in;
   logic [xs64_pkg::SEED_W-1:0] b_ff, b_in;
   logic [xs64_pkg::SEED_W-1:0] acc_ff, acc_in;
   logic [HALF_W-1:0]           op_x;
   logic [HALF_W-1:0]           op_y;
   logic [xs64_pkg::SEED_W-1:0] pp;

   always_comb begin
      op_x = (step_ff == STEP_HL) ? a_ff[xs64_pkg::SEED_W-1:HALF_W] : a_ff[HALF_W-1:0];
      op_y = (step_ff == STEP_LH) ? b_ff[xs64_pkg::SEED_W-1:HALF_W] : b_ff[HALF_W-1:0];
      pp   = {{HALF_W{1'b0}}, op_x} * {{HALF_W{1'b0}}, op_y};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (mul_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_LL;
         a_in    = mul_req.multiplicand;
         b_in    = mul_req.multiplier;
      end else if (busy_ff) begin
         case (step_ff)
            STEP_LL: begin
               acc_in  = pp;
               step_in = STEP_LH;
            end
            STEP_LH: begin
               acc_in  = acc_ff + {pp[HALF_W-1:0], {HALF_W{1'b0}}};
               step_in = STEP_HL;
            end
            default: begin
               acc_in  = acc_ff + {pp[HALF_W-1:0], {HALF_W{1'b0}}};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_LL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule
